### rtl/llte_pkg.sv
// Shared types and constants for the linked-list table engine.
`default_nettype none

package llte_pkg;

  localparam int unsigned LLTE_CAPACITY = 256;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 9;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned STAT_W        = 2;
  localparam logic [DATA_W-1:0] CLEARED_RST = 32'hFFFF_D499;

  typedef enum logic [KIND_W-1:0] {
    K_FRONT  = 3'd0,
    K_APPEND = 3'd1,
    K_AFTER  = 3'd2,
    K_REMOVE = 3'd3,
    K_SET    = 3'd4,
    K_GET    = 3'd5,
    K_SEARCH = 3'd6,
    K_HEAD   = 3'd7
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_WALK_START,
    DP_WALK,
    DP_TAKE_RD,
    DP_TAKE,
    DP_WR_A,
    DP_WR_B,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WSTART,
    S_WALK,
    S_POST,
    S_TAKE_RD,
    S_TAKE,
    S_WR_A,
    S_WR_B,
    S_FIN
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  head_none;
    logic  free_none;
    logic  pos_ok;
    logic  found;
    logic  walk_end;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/llte_ctrl.sv
// Command sequencer for the linked-list table engine.
`default_nettype none

module llte_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  llte_pkg::dp_stat_t   stat_i,
  output llte_pkg::ctrl_cmd_t  cmd_o
);
  import llte_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  // Hold state and result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_d = ST_OK;
        case (stat_i.kind)
          K_HEAD:   state_d = S_FIN;
          K_SEARCH: state_d = S_WSTART;
          K_FRONT: begin
            if (stat_i.free_none) begin
              st_d    = ST_FULL;
              state_d = S_FIN;
            end else begin
              state_d = S_TAKE_RD;
            end
          end
          K_APPEND: begin
            if (stat_i.free_none) begin
              st_d    = ST_FULL;
              state_d = S_FIN;
            end else begin
              state_d = S_WSTART;
            end
          end
          default: begin
            if (!stat_i.pos_ok) begin
              st_d    = ST_BADPOS;
              state_d = S_FIN;
            end else begin
              state_d = S_WSTART;
            end
          end
        endcase
      end
      S_WSTART: begin
        state_d = stat_i.head_none ? S_POST : S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_end) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (stat_i.kind == K_APPEND) begin
          state_d = S_TAKE_RD;
        end else if (stat_i.kind == K_SEARCH) begin
          state_d = S_FIN;
        end else if (!stat_i.found) begin
          st_d    = ST_BADPOS;
          state_d = S_FIN;
        end else begin
          case (stat_i.kind)
            K_AFTER: begin
              if (stat_i.free_none) begin
                st_d    = ST_FULL;
                state_d = S_FIN;
              end else begin
                state_d = S_TAKE_RD;
              end
            end
            K_REMOVE, K_SET: state_d = S_WR_A;
            default:         state_d = S_FIN;
          endcase
        end
      end
      S_TAKE_RD: state_d = S_TAKE;
      S_TAKE:    state_d = (stat_i.kind == K_FRONT) ? S_FIN : S_WR_A;
      S_WR_A:    state_d = (stat_i.kind == K_REMOVE) ? S_WR_B : S_FIN;
      S_WR_B:    state_d = S_FIN;
      S_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.st   = st_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
        end
      end
      S_WSTART:  cmd_o.op = DP_WALK_START;
      S_WALK:    cmd_o.op = DP_WALK;
      S_TAKE_RD: cmd_o.op = DP_TAKE_RD;
      S_TAKE:    cmd_o.op = DP_TAKE;
      S_WR_A:    cmd_o.op = DP_WR_A;
      S_WR_B:    cmd_o.op = DP_WR_B;
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = DP_FINISH;
        end
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

  // A result is only produced from the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_FINISH) |-> (state_q == S_FIN))
    else $error("finish issued outside final state");

  // After a finish the sequencer is back to taking items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == DP_FINISH) |=> in_ready_o)
    else $error("not idle after finish");

  // A walk only runs for commands that need the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (stat_i.kind != K_FRONT && stat_i.kind != K_HEAD))
    else $error("walk for a command without a walk");

endmodule

`default_nettype wire

### rtl/llte_dp.sv
// Datapath: link and element memories, list pointers, walk cursor, result register.
`default_nettype none

module llte_dp #(
  parameter int unsigned CAPACITY = llte_pkg::LLTE_CAPACITY
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  llte_pkg::ctrl_cmd_t                 cmd_i,
  output llte_pkg::dp_stat_t                  stat_o,
  input  wire  [llte_pkg::KIND_W-1:0]         kind_i,
  input  wire  [llte_pkg::POS_W-1:0]          position_i,
  input  wire  [llte_pkg::DATA_W-1:0]         value_i,
  input  wire                                 cfg_we_i,
  input  wire  [llte_pkg::DATA_W-1:0]         cfg_data_i,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic [llte_pkg::STAT_W-1:0]         status_o,
  output logic [llte_pkg::DATA_W-1:0]         element_o,
  output logic [llte_pkg::POS_W-1:0]          result_position_o,
  output logic [llte_pkg::LEN_W-1:0]          length_o
);
  import llte_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = IW + 1;
  localparam int unsigned WW = PW + POS_W;
  localparam logic [IW:0] NONE = {1'b1, {IW{1'b0}}};

  // Memories: an index with the top bit set means no node
  logic [IW:0]       link_mem [CAPACITY];
  logic [DATA_W-1:0] elem_mem [CAPACITY];

  logic [IW-1:0]     rd_addr, raddr_q;
  logic [IW:0]       link_rd_q;
  logic [DATA_W-1:0] elem_rd_q;
  logic              link_we, elem_we;
  logic [IW-1:0]     link_wa, elem_wa;
  logic [IW:0]       link_wd;
  logic [DATA_W-1:0] elem_wd;

  logic [IW:0]  head_q, free_q, cnt_q, hwm_q;
  logic [DATA_W-1:0] cleared_q;

  kind_e             kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [IW:0]       cur_q, pred_q, link_sv_q, new_q;
  logic [DATA_W-1:0] elem_sv_q;
  logic              found_q;

  logic              out_valid_q;
  status_e           out_st_q;
  logic [DATA_W-1:0] out_elem_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [LEN_W-1:0]  out_len_q;

  logic [IW:0]   fresh_nx, fresh, link_val, pos_node, res_ptr;
  logic [WW-1:0] pos_w, rp_w, len_w;
  logic          pos_ok, hit, walk_end;
  logic [DATA_W-1:0] res_elem;

  // Entries at or above the fill mark read as their reset chain link, the next index
  assign fresh_nx = {1'b0, raddr_q} + PW'(1);
  assign fresh    = (fresh_nx == PW'(CAPACITY)) ? NONE : fresh_nx;
  assign link_val = ({1'b0, raddr_q} >= hwm_q) ? fresh : link_rd_q;

  // Decode the named node
  assign pos_w    = WW'(pos_q[POS_W-2:0]);
  assign pos_ok   = !pos_q[POS_W-1] && (pos_w < WW'(CAPACITY));
  assign pos_node = {1'b0, pos_w[IW-1:0]};

  // Walk compare
  always_comb begin
    case (kind_q)
      K_AFTER, K_REMOVE, K_SET, K_GET: hit = (cur_q == pos_node);
      K_SEARCH:                        hit = (elem_rd_q == val_q);
      default:                         hit = 1'b0;
    endcase
  end
  assign walk_end = hit || link_val[IW];

  // Read address
  always_comb begin
    case (cmd_i.op)
      DP_WALK_START: rd_addr = head_q[IW-1:0];
      DP_WALK:       rd_addr = link_val[IW-1:0];
      DP_TAKE_RD:    rd_addr = free_q[IW-1:0];
      default:       rd_addr = raddr_q;
    endcase
  end

  // Write ports
  always_comb begin
    link_we = 1'b0;
    link_wa = cur_q[IW-1:0];
    link_wd = new_q;
    elem_we = 1'b0;
    elem_wa = cur_q[IW-1:0];
    elem_wd = val_q;
    case (cmd_i.op)
      DP_TAKE: begin
        link_we = 1'b1;
        link_wa = free_q[IW-1:0];
        elem_we = 1'b1;
        elem_wa = free_q[IW-1:0];
        case (kind_q)
          K_FRONT:  link_wd = head_q;
          K_APPEND: link_wd = NONE;
          default:  link_wd = link_sv_q;
        endcase
      end
      DP_WR_A: begin
        case (kind_q)
          K_REMOVE: begin
            link_we = 1'b1;
            link_wd = free_q;
            elem_we = 1'b1;
            elem_wd = cleared_q;
          end
          K_SET:    elem_we = 1'b1;
          K_APPEND: link_we = !cur_q[IW];
          K_AFTER:  link_we = 1'b1;
          default:  link_we = 1'b0;
        endcase
      end
      DP_WR_B: begin
        link_we = !pred_q[IW];
        link_wa = pred_q[IW-1:0];
        link_wd = link_sv_q;
      end
      default: link_we = 1'b0;
    endcase
  end

  // Memory arrays with registered read
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_wa] <= elem_wd;
    end
    elem_rd_q <= elem_mem[rd_addr];
    raddr_q   <= rd_addr;
  end

  // List pointers, counts and register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= NONE;
      free_q    <= '0;
      cnt_q     <= '0;
      hwm_q     <= '0;
      cleared_q <= CLEARED_RST;
    end else begin
      if (cfg_we_i) begin
        cleared_q <= cfg_data_i;
      end
      case (cmd_i.op)
        DP_TAKE: begin
          free_q <= link_val;
          cnt_q  <= cnt_q + PW'(1);
          if (free_q == hwm_q) begin
            hwm_q <= hwm_q + PW'(1);
          end
          if (kind_q == K_FRONT || (kind_q == K_APPEND && cur_q[IW])) begin
            head_q <= free_q;
          end
        end
        DP_WR_A: begin
          if (kind_q == K_REMOVE) begin
            free_q <= cur_q;
            cnt_q  <= cnt_q - PW'(1);
            if (pred_q[IW]) begin
              head_q <= link_sv_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Command fields and walk cursor
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        kind_q <= kind_e'(kind_i);
        pos_q  <= position_i;
        val_q  <= value_i;
      end
      DP_WALK_START: begin
        cur_q   <= head_q;
        pred_q  <= NONE;
        found_q <= 1'b0;
      end
      DP_WALK: begin
        if (walk_end) begin
          found_q   <= hit;
          link_sv_q <= link_val;
          elem_sv_q <= elem_rd_q;
        end else begin
          cur_q  <= link_val;
          pred_q <= cur_q;
        end
      end
      DP_TAKE: new_q <= free_q;
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    res_elem = '0;
    res_ptr  = NONE;
    if (cmd_i.st == ST_OK) begin
      case (kind_q)
        K_FRONT, K_APPEND, K_AFTER: res_ptr = new_q;
        K_REMOVE: begin
          res_ptr  = link_sv_q;
          res_elem = elem_sv_q;
        end
        K_SET, K_GET: res_elem = elem_sv_q;
        K_SEARCH:     res_ptr  = found_q ? cur_q : NONE;
        default:      res_ptr  = head_q;
      endcase
    end
  end
  assign rp_w  = WW'(res_ptr[IW-1:0]);
  assign len_w = WW'(cnt_q);

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_FINISH) begin
      out_st_q   <= cmd_i.st;
      out_elem_q <= res_elem;
      out_pos_q  <= res_ptr[IW] ? {POS_W{1'b1}} : rp_w[POS_W-1:0];
      out_len_q  <= len_w[LEN_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_st_q;
  assign element_o         = out_elem_q;
  assign result_position_o = out_pos_q;
  assign length_o          = out_len_q;

  assign stat_o.kind      = kind_q;
  assign stat_o.head_none = head_q[IW];
  assign stat_o.free_none = free_q[IW];
  assign stat_o.pos_ok    = pos_ok;
  assign stat_o.found     = found_q;
  assign stat_o.walk_end  = walk_end;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PW'(CAPACITY))
    else $error("element count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q[IW] == (cnt_q == '0))
    else $error("list head disagrees with element count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q[IW] == (cnt_q == PW'(CAPACITY)))
    else $error("free head disagrees with element count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q >= cnt_q)
    else $error("fill mark below element count");

endmodule

`default_nettype wire

### rtl/linked_list_table_engine.sv
// Linked-list table engine: top level joining the sequencer and the datapath.
//
// Usage:
//   s_axis: one command item per handshake. tuser carries the kind, tdata the
//   node position and the element value. m_axis: one result item per command;
//   tuser carries the status, tdata the element, result position and length.
//   cfg: a write of the cleared value, taken in any cycle (ready is high).
// Timing: one command at a time. Commands that walk the chain visit its nodes
//   one at a time, as the link memory has a single read port; head query, front
//   insert and commands rejected at dispatch do not walk the chain. The next
//   command can be accepted once the result is posted.
// Reset: the list is empty, the free list runs 0, 1, 2 ... in order and the
//   cleared value is -11111; the memories need no clearing pass.
// Stall: a finished result waits in the output register; the next command is
//   accepted while it waits and completes once the register has been taken.
`default_nettype none

module linked_list_table_engine #(
  parameter int unsigned CAPACITY = llte_pkg::LLTE_CAPACITY
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [2:0]  s_axis_tuser_i,  // kind[2:0]
  input  wire  [47:0] s_axis_tdata_i,  // position[8:0], value[40:9], zeros[47:41]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [1:0]  m_axis_tuser_o,  // status[1:0]
  output logic [55:0] m_axis_tdata_o,  // element[31:0], result_position[40:32],
                                       // length[49:41], zeros[55:50]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i
);
  import llte_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] element;
  logic [POS_W-1:0]  result_position;
  logic [LEN_W-1:0]  length;

  assign cfg_ready_o = 1'b1;

  llte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  llte_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (s_axis_tuser_i),
    .position_i        (s_axis_tdata_i[8:0]),
    .value_i           (s_axis_tdata_i[40:9]),
    .cfg_we_i          (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .status_o          (status),
    .element_o         (element),
    .result_position_o (result_position),
    .length_o          (length)
  );

  // Pack the result item
  assign m_axis_tuser_o = status;
  assign m_axis_tdata_o = {6'b0, length, result_position, element};

endmodule

`default_nettype wire
